// File: design/apd_pkg.sv
// Shared types and constants for the audio packet deframer.
package apd_pkg;

  localparam int HDR_LEN    = 40;
  localparam int HDR_BITS   = HDR_LEN * 8;
  localparam int HCNT_W     = 6;
  localparam int PCNT_W     = 34;
  localparam int PART_W     = 24;
  localparam int FIFO_DEPTH = 4;
  localparam int TDATA_W    = 280;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_MAGIC    = 3'd2,
    ST_VERSION  = 3'd3,
    ST_FORMAT   = 3'd4,
    ST_CHANNELS = 3'd5,
    ST_LENGTH   = 3'd6
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAGIC    = 2'd0,
    CFG_VERSION  = 2'd1,
    CFG_FORMAT   = 2'd2,
    CFG_CHANNELS = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] magic;
    logic [15:0] version;
    logic [15:0] format;
    logic [15:0] channels;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    status_t     status;
    logic [15:0] hdr_flags;
    logic [63:0] lease_tag;
    logic [63:0] sequence_number;
    logic [63:0] first_sample;
    logic [31:0] declared_samples;
    logic [31:0] sample_bits;
    logic        packet_done;
  } res_t;

endpackage

// File: design/apd_cfg.sv
// Check registers for the header compare.
module apd_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [apd_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [apd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output apd_pkg::cfg_t                   cfg
);

  apd_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (apd_pkg::cfg_idx_t'(cfg_addr))
        apd_pkg::CFG_MAGIC:    cfg_nxt.magic    = cfg_wdata;
        apd_pkg::CFG_VERSION:  cfg_nxt.version  = cfg_wdata[15:0];
        apd_pkg::CFG_FORMAT:   cfg_nxt.format   = cfg_wdata[15:0];
        apd_pkg::CFG_CHANNELS: cfg_nxt.channels = cfg_wdata[15:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: design/apd_parse.sv
// Per-byte packet parser: header gather and check, sample assembly, end status.
module apd_parse (
  input  logic          clk,
  input  logic          rst_n,
  input  apd_pkg::cfg_t cfg,
  input  logic          in_fire,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  output logic          res0_vld,
  output apd_pkg::res_t res0,
  output logic          res1_vld,
  output apd_pkg::res_t res1
);

  localparam int HB = apd_pkg::HDR_BITS;

  logic [apd_pkg::HCNT_W-1:0] hcnt_r, hcnt_nxt;
  logic [HB-1:0]              hdr_r, hdr_nxt, hdr_cur;
  logic [apd_pkg::PCNT_W-1:0] pcnt_r, pcnt_nxt;
  logic [apd_pkg::PART_W-1:0] part_r, part_nxt;
  logic                       hval_r, hval_nxt;
  apd_pkg::status_t           fail_r, fail_nxt;

  logic             in_hdr, hdr_done, in_pay, smp_emit, first_vld, pkt_end;
  logic [1:0]       phase;
  logic [31:0]      decl;
  apd_pkg::status_t chk, st;
  apd_pkg::res_t    hdr_res, smp_res, st_res;

  always_comb begin
    hcnt_nxt = hcnt_r;
    hdr_nxt  = hdr_r;
    pcnt_nxt = pcnt_r;
    part_nxt = part_r;
    hval_nxt = hval_r;
    fail_nxt = fail_r;

    in_hdr  = hcnt_r < apd_pkg::HCNT_W'(apd_pkg::HDR_LEN);
    // header shifts in from the top; byte 0 ends up in the low bits
    hdr_cur = in_hdr ? {in_byte, hdr_r[HB-1:8]} : hdr_r;
    hdr_done = in_fire && (hcnt_r == apd_pkg::HCNT_W'(apd_pkg::HDR_LEN - 1));
    pkt_end  = in_fire && in_last;
    decl     = hdr_cur[287:256];

    priority if (hdr_cur[31:0] != cfg.magic)      chk = apd_pkg::ST_MAGIC;
    else if (hdr_cur[47:32] != cfg.version)        chk = apd_pkg::ST_VERSION;
    else if (hdr_cur[303:288] != cfg.format)       chk = apd_pkg::ST_FORMAT;
    else if (hdr_cur[319:304] != cfg.channels)     chk = apd_pkg::ST_CHANNELS;
    else                                           chk = apd_pkg::ST_OK;

    phase    = pcnt_r[1:0];
    in_pay   = in_fire && !in_hdr && hval_r && (pcnt_r != '1);
    smp_emit = in_pay && (phase == 2'd3);

    if (in_fire && in_hdr) begin
      hdr_nxt  = hdr_cur;
      hcnt_nxt = hcnt_r + 1'b1;
    end
    if (hdr_done) begin
      fail_nxt = chk;
      hval_nxt = (chk == apd_pkg::ST_OK);
    end
    if (in_pay) begin
      pcnt_nxt = pcnt_r + 1'b1;
      if (phase == 2'd3) begin
        part_nxt = '0;
      end else begin
        part_nxt = part_r | (apd_pkg::PART_W'(in_byte) << {phase, 3'b000});
      end
    end

    priority if (hcnt_nxt < apd_pkg::HCNT_W'(apd_pkg::HDR_LEN)) st = apd_pkg::ST_SHORT;
    else if (!hval_nxt)                                         st = fail_nxt;
    else if (pcnt_nxt != {decl, 2'b00})                         st = apd_pkg::ST_LENGTH;
    else                                                        st = apd_pkg::ST_OK;

    if (pkt_end) begin
      hcnt_nxt = '0;
      pcnt_nxt = '0;
      part_nxt = '0;
      hval_nxt = 1'b0;
      fail_nxt = apd_pkg::ST_OK;
    end
  end

  always_comb begin
    hdr_res                  = '0;
    hdr_res.kind             = apd_pkg::KIND_HEADER;
    hdr_res.status           = apd_pkg::ST_OK;
    hdr_res.hdr_flags        = hdr_cur[63:48];
    hdr_res.lease_tag        = hdr_cur[127:64];
    hdr_res.sequence_number  = hdr_cur[191:128];
    hdr_res.first_sample     = hdr_cur[255:192];
    hdr_res.declared_samples = decl;

    smp_res             = '0;
    smp_res.kind        = apd_pkg::KIND_SAMPLE;
    smp_res.status      = apd_pkg::ST_OK;
    smp_res.sample_bits = {in_byte, part_r};

    st_res             = '0;
    st_res.kind        = apd_pkg::KIND_STATUS;
    st_res.status      = st;
    st_res.packet_done = 1'b1;

    first_vld = (hdr_done && (chk == apd_pkg::ST_OK)) || smp_emit;
    res0_vld  = first_vld || pkt_end;
    res0      = first_vld ? (hdr_done ? hdr_res : smp_res) : st_res;
    res1_vld  = first_vld && pkt_end;
    res1      = st_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hcnt_r <= '0;
      pcnt_r <= '0;
      part_r <= '0;
      hval_r <= 1'b0;
      fail_r <= apd_pkg::ST_OK;
    end else begin
      hcnt_r <= hcnt_nxt;
      pcnt_r <= pcnt_nxt;
      part_r <= part_nxt;
      hval_r <= hval_nxt;
      fail_r <= fail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_r <= hdr_nxt;
  end

`ifndef SYNTHESIS
  a_hcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    hcnt_r <= apd_pkg::HCNT_W'(apd_pkg::HDR_LEN))
    else $error("header count past header length");

  a_hval_full: assert property (@(posedge clk) disable iff (!rst_n)
    hval_r |-> (hcnt_r == apd_pkg::HCNT_W'(apd_pkg::HDR_LEN)) && (fail_r == apd_pkg::ST_OK))
    else $error("header accepted before full or with a failure code");

  a_pay_needs_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    (pcnt_r != '0) |-> hval_r)
    else $error("payload counted without an accepted header");

  a_end_status: assert property (@(posedge clk) disable iff (!rst_n)
    pkt_end |-> (res1_vld ? res1.packet_done : res0.packet_done))
    else $error("last byte produced no end status");
`endif

endmodule

// File: design/apd_fifo.sv
// Result queue: takes up to two words a cycle, hands out one.
module apd_fifo #(
  parameter int DEPTH = apd_pkg::FIFO_DEPTH  // power of two, at least 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr0_vld,
  input  apd_pkg::res_t wr0,
  input  logic          wr1_vld,
  input  apd_pkg::res_t wr1,
  output logic          room2,
  output logic          rd_vld,
  input  logic          rd_rdy,
  output apd_pkg::res_t rd_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = PW + 1;

  apd_pkg::res_t  mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           pop;

  always_comb begin
    pop        = rd_vld && rd_rdy;
    wr_ptr_nxt = wr_ptr_r + PW'(wr0_vld) + PW'(wr1_vld);
    rd_ptr_nxt = rd_ptr_r + PW'(pop);
    cnt_nxt    = cnt_r + CW'(wr0_vld) + CW'(wr1_vld) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (wr0_vld) mem_r[wr_ptr_r] <= wr0;
    if (wr1_vld) mem_r[wr_ptr_r + PW'(1)] <= wr1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  assign room2   = cnt_r <= CW'(DEPTH - 2);
  assign rd_vld  = cnt_r != '0;
  assign rd_data = mem_r[rd_ptr_r];

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("result queue overflow");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    wr1_vld |-> wr0_vld)
    else $error("second slot written without the first");
`endif

endmodule

// File: design/audio_packet_deframer_core.sv
// Audio packet deframer top level: config registers, parser, result queue.
//
//   channel | dir | tdata (low bit up)                       | tuser | tlast
//   --------+-----+------------------------------------------+-------+-------------
//   in_     | in  | data_byte                                | -     | end_of_packet
//   out_    | out | status, hdr_flags, lease_tag, seq number,| kind  | packet_done
//           |     | first_sample, declared_samples, sample   |       |
//   cfg_    | in  | write: cfg_addr selects, cfg_wdata value | -     | -
//
// One byte is taken per cycle while in_tready is high; its results are written
// into the result queue in the same cycle and can leave on the next edge. A byte
// yields at most two words (header or sample, then end status). in_tready is high
// while the queue has room for two words, so a stalled output backs up the input
// once fewer than two entries are free. Reset is synchronous and clears all control state.
module audio_packet_deframer_core #(
  parameter int FIFO_DEPTH = apd_pkg::FIFO_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // data_byte
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // status[2:0] hdr_flags[18:3] lease_tag[82:19] sequence_number[146:83]
  // first_sample[210:147] declared_samples[242:211] sample_bits[274:243]
  output logic [apd_pkg::TDATA_W-1:0]      out_tdata,
  output logic [1:0]                       out_tuser,  // kind
  output logic                             out_tlast,
  input  logic                             cfg_we,
  input  logic [apd_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [apd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  apd_pkg::cfg_t cfg;
  apd_pkg::res_t res0, res1, head;
  logic          res0_vld, res1_vld, room2, in_fire;

  assign in_tready = room2;
  assign in_fire   = in_tvalid && in_tready;

  apd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  apd_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_fire  (in_fire),
    .in_byte  (in_tdata),
    .in_last  (in_tlast),
    .res0_vld (res0_vld),
    .res0     (res0),
    .res1_vld (res1_vld),
    .res1     (res1)
  );

  apd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr0_vld (res0_vld),
    .wr0     (res0),
    .wr1_vld (res1_vld),
    .wr1     (res1),
    .room2   (room2),
    .rd_vld  (out_tvalid),
    .rd_rdy  (out_tready),
    .rd_data (head)
  );

  assign out_tdata = {5'b00000, head.sample_bits, head.declared_samples, head.first_sample,
                      head.sequence_number, head.lease_tag, head.hdr_flags, head.status};
  assign out_tuser = head.kind;
  assign out_tlast = head.packet_done;

endmodule
